### hdl/hvt_pkg.sv
// Package with the constants, types and helpers of the homogeneous vertex transform unit.
package hvt_pkg;

   localparam int FracBitsDefault = 16;
   localparam int NumPairs        = 8;
   localparam int CsrIndexWidth   = 3;
   localparam int WordWidth       = 32;
   localparam int PairWidth       = 64;
   localparam int ProdWidth       = 64;
   localparam int SumWidth        = 66;
   localparam int DivNumWidth     = 32 + 24 + 1;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_ZERO_W    = 2'd1,
      STATUS_SATURATED = 2'd2
   } status_type;

   typedef enum logic {
      ACTION_VECTOR = 1'b0,
      ACTION_POINT  = 1'b1
   } action_type;

   typedef struct packed {
      logic       valid;
      action_type action;
      logic       sat;
   } ctrl_type;

   // Saturate a wide signed value to 32 bits; the flag is set when it clipped.
   function automatic logic [32:0] clamp_word(input logic signed [SumWidth-1:0] v);
      logic signed [SumWidth-1:0] max_v;
      logic signed [SumWidth-1:0] min_v;
      logic [32:0]                res;
      max_v = SumWidth'(signed'(33'sh0_7FFF_FFFF));
      min_v = -max_v - SumWidth'(1);
      if (v > max_v) begin
         res = {1'b1, 32'h7FFF_FFFF};
      end else if (v < min_v) begin
         res = {1'b1, 32'h8000_0000};
      end else begin
         res = {1'b0, v[31:0]};
      end
      return res;
   endfunction

endpackage

### hdl/hvt_divider.sv
// Pipelined restoring signed divider: one quotient bit per stage, truncation toward zero.
module hvt_divider #(
   parameter int FRAC_BITS = hvt_pkg::FracBitsDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   input  logic signed [hvt_pkg::WordWidth-1:0] in_num,
   input  logic signed [hvt_pkg::WordWidth-1:0] in_den,
   input  logic [hvt_pkg::WordWidth*3-1:0]      in_tag,
   output logic                                 out_valid,
   output logic signed [hvt_pkg::WordWidth-1:0] out_quot,
   output logic                                 out_sat,
   output logic [hvt_pkg::WordWidth*3-1:0]      out_tag
);
   import hvt_pkg::*;

   // Numerator is num << FRAC_BITS, magnitude below 2^(31+FRAC_BITS)+1.
   localparam int NumW   = WordWidth + FRAC_BITS;
   localparam int Stages = NumW;

   logic [NumW-1:0]      num_ff   [Stages+1];
   logic [NumW-1:0]      quot_ff  [Stages+1];
   logic [NumW:0]        rem_ff   [Stages+1];
   logic [WordWidth-1:0] den_ff   [Stages+1];
   logic                 neg_ff   [Stages+1];
   logic                 vld_ff   [Stages+1];
   logic [WordWidth*3-1:0] tag_ff [Stages+1];

   logic [NumW-1:0] num_mag_in;
   logic [WordWidth-1:0] den_mag_in;

   always_comb begin
      logic [NumW-1:0] n;
      n = {in_num, FRAC_BITS'(0)};
      num_mag_in = in_num[WordWidth-1] ? (~n + NumW'(1)) : n;
      den_mag_in = in_den[WordWidth-1] ? (~in_den + WordWidth'(1)) : in_den;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
      num_ff[0]  <= num_mag_in;
      quot_ff[0] <= '0;
      rem_ff[0]  <= '0;
      den_ff[0]  <= den_mag_in;
      neg_ff[0]  <= in_num[WordWidth-1] ^ in_den[WordWidth-1];
      tag_ff[0]  <= in_tag;
   end

   for (genvar s = 0; s < Stages; s++) begin : g_stage
      logic [NumW:0] shifted;
      logic [NumW:0] diff;
      logic          ge;
      always_comb begin
         shifted = {rem_ff[s][NumW-1:0], num_ff[s][NumW-1-s]};
         diff    = shifted - (NumW+1)'(den_ff[s]);
         ge      = shifted >= (NumW+1)'(den_ff[s]);
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else begin
            vld_ff[s+1] <= vld_ff[s];
         end
         num_ff[s+1]  <= num_ff[s];
         rem_ff[s+1]  <= ge ? diff : shifted;
         quot_ff[s+1] <= quot_ff[s] | (ge ? (NumW'(1) << (NumW-1-s)) : NumW'(0));
         den_ff[s+1]  <= den_ff[s];
         neg_ff[s+1]  <= neg_ff[s];
         tag_ff[s+1]  <= tag_ff[s];
      end
   end

   always_comb begin
      logic [NumW:0]             mag;
      logic signed [SumWidth-1:0] q;
      logic [32:0]               c;
      mag = {1'b0, quot_ff[Stages]};
      q = neg_ff[Stages] ? -SumWidth'(signed'(mag)) : SumWidth'(signed'(mag));
      c = clamp_word(q);
      out_sat  = c[32];
      out_quot = c[31:0];
   end
   assign out_valid = vld_ff[Stages];
   assign out_tag   = tag_ff[Stages];

endmodule

### hdl/homogeneous_vertex_transform_unit.sv
// Top level of the homogeneous vertex transform unit.
// The unit multiplies one vector by a row-major 4x4 matrix of signed Q fixed-point
// entries held in eight 64-bit configuration registers (reset: identity).
// A transaction is accepted on a rising edge with start high and busy low;
// busy is tied low, since the pipeline takes one transaction in every cycle.
// With req_action 0 the full product is returned. With req_action 1 the vector is
// the point (x, y, z, 1.0) and x, y and z are divided by the product's w.
// Results appear on the rsp_ ports for one cycle with rsp_strobe high.
// The path runs through the multiply, sum and saturate stages, one
// input stage of the divider and WordWidth + FRAC_BITS divider stages (48 at the
// default), for both actions; throughput is one per cycle.
// Vector transactions pass through the divider pipeline unchanged as tag data.
// The receiver cannot stall, so no back pressure exists anywhere.
// Reset clears all valid bits and restores the identity matrix.
// Configuration writes through csr_ take effect at the next edge and must only
// be issued while no transaction is in flight.
module homogeneous_vertex_transform_unit #(
   parameter int FRAC_BITS = hvt_pkg::FracBitsDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_action,
   input  logic signed [hvt_pkg::WordWidth-1:0] req_in_x,
   input  logic signed [hvt_pkg::WordWidth-1:0] req_in_y,
   input  logic signed [hvt_pkg::WordWidth-1:0] req_in_z,
   input  logic signed [hvt_pkg::WordWidth-1:0] req_in_w,
   input  logic                                csr_write,
   input  logic [hvt_pkg::CsrIndexWidth:0]     csr_index,
   input  logic [hvt_pkg::PairWidth-1:0]       csr_data,
   output logic                                rsp_strobe,
   output logic signed [hvt_pkg::WordWidth-1:0] rsp_out_x,
   output logic signed [hvt_pkg::WordWidth-1:0] rsp_out_y,
   output logic signed [hvt_pkg::WordWidth-1:0] rsp_out_z,
   output logic signed [hvt_pkg::WordWidth-1:0] rsp_out_w,
   output logic [1:0]                          rsp_status
);
   import hvt_pkg::*;

   localparam logic [WordWidth-1:0] QOne = WordWidth'(1) << FRAC_BITS;

   logic [PairWidth-1:0] matrix_ff [NumPairs];

   // Configuration registers; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumPairs; i++) begin
            matrix_ff[i] <= '0;
         end
         matrix_ff[0] <= PairWidth'(QOne);
         matrix_ff[2] <= {QOne, WordWidth'(0)};
         matrix_ff[5] <= PairWidth'(QOne);
         matrix_ff[7] <= {QOne, WordWidth'(0)};
      end else if (csr_write && !csr_index[CsrIndexWidth]) begin
         matrix_ff[csr_index[CsrIndexWidth-1:0]] <= csr_data;
      end
   end

   assign busy = 1'b0;

   // Stage 1: sixteen 32x32 products.
   logic signed [WordWidth-1:0] vec [4];
   always_comb begin
      vec[0] = req_in_x;
      vec[1] = req_in_y;
      vec[2] = req_in_z;
      vec[3] = req_action ? signed'(QOne) : req_in_w;
   end

   ctrl_type c1_ff, c2_ff, c3_ff;
   logic signed [ProdWidth-1:0] prod_ff [4][4];
   logic signed [SumWidth-1:0]  sum_ff  [4];
   logic signed [WordWidth-1:0] row_ff  [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff.valid <= 1'b0;
      end else begin
         c1_ff.valid <= start;
      end
      c1_ff.action <= action_type'(req_action);
      c1_ff.sat    <= 1'b0;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            prod_ff[r][c] <= ProdWidth'(signed'(matrix_ff[r*2 + c/2][(c%2)*32 +: 32]))
                           * ProdWidth'(vec[c]);
         end
      end
   end

   // Stage 2: exact row sums. Floor-shifting the exact sum equals the split
   // form, since the low fraction parts only carry into the integer part.
   always_ff @(posedge clock) begin
      if (reset) begin
         c2_ff.valid <= 1'b0;
      end else begin
         c2_ff.valid <= c1_ff.valid;
      end
      c2_ff.action <= c1_ff.action;
      c2_ff.sat    <= 1'b0;
      for (int r = 0; r < 4; r++) begin
         sum_ff[r] <= SumWidth'(prod_ff[r][0]) + SumWidth'(prod_ff[r][1])
                    + SumWidth'(prod_ff[r][2]) + SumWidth'(prod_ff[r][3]);
      end
   end

   // Stage 3: arithmetic shift (floor) and saturation.
   logic [32:0] clamp_res [4];
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         clamp_res[r] = clamp_word(sum_ff[r] >>> FRAC_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c3_ff.valid <= 1'b0;
      end else begin
         c3_ff.valid <= c2_ff.valid;
      end
      c3_ff.action <= c2_ff.action;
      c3_ff.sat    <= clamp_res[0][32] | clamp_res[1][32] | clamp_res[2][32]
                    | clamp_res[3][32];
      for (int r = 0; r < 4; r++) begin
         row_ff[r] <= clamp_res[r][31:0];
      end
   end

   // Three dividers share one divisor; control and w ride along as tag data.
   localparam int TagW = WordWidth*3;
   logic                       dv_valid [3];
   logic signed [WordWidth-1:0] dv_quot [3];
   logic                       dv_sat [3];
   logic [TagW-1:0]            dv_tag [3];
   logic [TagW-1:0]            tag_in [3];

   always_comb begin
      // tag 0 carries the row sum for vector mode, tag 1 the w and control.
      tag_in[0] = {row_ff[0], row_ff[1], row_ff[2]};
      tag_in[1] = {row_ff[3], 61'(0), c3_ff.valid, c3_ff.action, c3_ff.sat};
      tag_in[2] = '0;
   end

   for (genvar k = 0; k < 3; k++) begin : g_div
      hvt_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (c3_ff.valid),
         .in_num    (row_ff[k]),
         .in_den    (row_ff[3]),
         .in_tag    (tag_in[k]),
         .out_valid (dv_valid[k]),
         .out_quot  (dv_quot[k]),
         .out_sat   (dv_sat[k]),
         .out_tag   (dv_tag[k])
      );
   end

   // Result selection.
   logic        o_action;
   logic        o_sat;
   logic [WordWidth-1:0] o_w;
   always_comb begin
      o_action = dv_tag[1][1];
      o_sat    = dv_tag[1][0];
      o_w      = dv_tag[1][TagW-1 -: WordWidth];
      rsp_strobe = dv_valid[0];
      if (o_action == ACTION_VECTOR) begin
         rsp_out_x  = dv_tag[0][TagW-1 -: WordWidth];
         rsp_out_y  = dv_tag[0][WordWidth*2-1 -: WordWidth];
         rsp_out_z  = dv_tag[0][WordWidth-1:0];
         rsp_out_w  = o_w;
         rsp_status = o_sat ? STATUS_SATURATED : STATUS_OK;
      end else if (o_w == '0) begin
         rsp_out_x  = '0;
         rsp_out_y  = '0;
         rsp_out_z  = '0;
         rsp_out_w  = '0;
         rsp_status = STATUS_ZERO_W;
      end else begin
         rsp_out_x  = dv_quot[0];
         rsp_out_y  = dv_quot[1];
         rsp_out_z  = dv_quot[2];
         rsp_out_w  = QOne;
         rsp_status = (o_sat | dv_sat[0] | dv_sat[1] | dv_sat[2])
                    ? STATUS_SATURATED : STATUS_OK;
      end
   end

   logic unused_ok;
   assign unused_ok = dv_valid[1] ^ dv_valid[2] ^ (|dv_tag[2]) ^ (|dv_tag[1][TagW-WordWidth-1:3]);

   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      dv_valid[0] == dv_valid[1] && dv_valid[1] == dv_valid[2])
      else $error("divider lanes out of step");
   // The tag registers are not reset, so only a valid lane is compared.
   a_tag_valid: assert property (@(posedge clock) disable iff (reset)
      dv_valid[0] |-> dv_tag[1][2])
      else $error("tag valid disagrees with divider valid");
   a_stage_follow: assert property (@(posedge clock) disable iff (reset)
      c1_ff.valid |=> c2_ff.valid)
      else $error("transaction lost between stages");
   a_zero_status: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == STATUS_ZERO_W |-> rsp_out_w == '0)
      else $error("zero w result not cleared");

endmodule
